/* src/svo_pkg.sv */
// ----------------------------------------------------------------------------
// svo_pkg: shared types and codes for the sparse voxel octree store
// Beat layouts, command and status codes, per-node metadata word.
// ----------------------------------------------------------------------------
package svo_pkg;

  localparam int unsigned DEF_MAX_DEPTH = 6;
  localparam int unsigned DEF_NODE_POOL = 1024;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] pos_x;
    logic [5:0] pos_y;
    logic [5:0] pos_z;
    logic [7:0] material;
  } item_t;

  typedef struct packed {
    logic [7:0] read_material;
    logic [1:0] status;
  } result_t;

  // mask bit set = that child link was written since the node was allocated
  typedef struct packed {
    logic       leaf;
    logic [7:0] mask;
    logic [7:0] material;
  } node_meta_t;

endpackage

/* src/sparse_voxel_octree_store_unit.sv */
// ----------------------------------------------------------------------------
// sparse_voxel_octree_store_unit: sparse voxel octree material store
// Insert, read and clear of voxel materials held in a fixed node pool.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken at a clock edge with start high and busy low.
//   Every command gives exactly one result beat: done is high for one cycle
//   with result valid; the receiver cannot stall, so it must take it then.
//   Clear, empty insert and the unused command: result in the cycle after
//   the command is taken, busy never rises.
//   Insert and read walk the tree one level at a time through a single
//   sequencer: one state reads the child link RAM, the next either reads the
//   child's metadata word (hit) or allocates and clears a new node (insert
//   miss). A read that meets an absent child ends early. One command at a
//   time; the next can be taken in the cycle done is high.
//   Child links of a node count only where its metadata mask bit is set, so
//   neither reset nor allocation sweeps the link RAM: no clearing pass.
//   Reset empties the tree and sets the allocator to one (root is node 0).
// ----------------------------------------------------------------------------
module sparse_voxel_octree_store_unit #(
  parameter int unsigned MAX_DEPTH = svo_pkg::DEF_MAX_DEPTH,
  parameter int unsigned NODE_POOL = svo_pkg::DEF_NODE_POOL
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  svo_pkg::item_t   item,
  output logic             busy,
  output logic             done,
  output svo_pkg::result_t result
);

  import svo_pkg::*;

  localparam int unsigned NODE_W     = $clog2(NODE_POOL);
  localparam int unsigned LINK_AW    = NODE_W + 3;
  localparam int unsigned LINK_DEPTH = NODE_POOL * 8;
  localparam int unsigned FREE_W     = $clog2(NODE_POOL + 1);
  localparam int unsigned LVL_W      = $clog2(MAX_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CHK   = 6'b000100,
    S_META  = 6'b001000,
    S_ALLOC = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t            state;
  item_t             item_q;
  logic [NODE_W-1:0] cur;
  logic [LVL_W-1:0]  level;
  node_meta_t        meta;
  logic [7:0]        root_mask;
  logic [FREE_W-1:0] next_free;

  logic [LVL_W-1:0]   shamt;
  logic [2:0]         oct;
  logic [7:0]         oct_bit;
  logic [LINK_AW-1:0] link_addr;
  logic               link_we;
  logic [NODE_W-1:0]  link_rdata;
  logic               node_we;
  logic [NODE_W-1:0]  node_addr;
  node_meta_t         node_wdata;
  node_meta_t         node_rdata;
  logic [NODE_W-1:0]  new_node;
  logic               hit;
  logic               at_last;
  logic               pool_full;

  // octant bits, most significant coordinate bit first
  assign shamt   = LVL_W'(MAX_DEPTH - 1) - level;
  assign oct     = {1'(item_q.pos_z >> shamt), 1'(item_q.pos_y >> shamt),
                    1'(item_q.pos_x >> shamt)};
  assign oct_bit = 8'b1 << oct;

  assign link_addr = {cur, oct};
  assign new_node  = next_free[NODE_W-1:0];
  assign hit       = meta.mask[oct];
  assign at_last   = (level == LVL_W'(MAX_DEPTH));
  assign pool_full = (next_free == FREE_W'(NODE_POOL));
  assign busy      = (state != S_IDLE);

  always_comb begin
    link_we    = 1'b0;
    node_we    = 1'b0;
    node_addr  = cur;
    node_wdata = meta;
    case (state)
      S_CHK: begin
        if (hit) begin
          node_addr = link_rdata;
        end else if (item_q.cmd == CMD_INSERT && !pool_full) begin
          link_we = 1'b1;
          // root metadata lives in flops
          if (cur != '0) begin
            node_we         = 1'b1;
            node_wdata.mask = meta.mask | oct_bit;
          end
        end
      end
      S_ALLOC: begin
        node_we    = 1'b1;
        node_wdata = '0;
      end
      S_FIN: begin
        if (item_q.cmd == CMD_INSERT) begin
          node_we             = 1'b1;
          node_wdata.leaf     = 1'b1;
          node_wdata.material = item_q.material;
        end
      end
      default: begin
      end
    endcase
  end

  svo_ram #(
    .WIDTH (NODE_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .addr  (link_addr),
    .wdata (new_node),
    .rdata (link_rdata)
  );

  svo_ram #(
    .WIDTH ($bits(node_meta_t)),
    .DEPTH (NODE_POOL)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .addr  (node_addr),
    .wdata (node_wdata),
    .rdata (node_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      root_mask <= '0;
      next_free <= FREE_W'(1);
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            item_q        <= item;
            cur           <= '0;
            level         <= '0;
            meta.leaf     <= 1'b0;
            meta.mask     <= root_mask;
            meta.material <= '0;
            if ((item.cmd == CMD_INSERT && item.material != '0) ||
                item.cmd == CMD_READ) begin
              state <= S_RD;
            end else begin
              done                 <= 1'b1;
              result.read_material <= '0;
              result.status        <= (item.cmd == CMD_INSERT) ? STAT_EMPTY : STAT_DONE;
              if (item.cmd == CMD_CLEAR) begin
                root_mask <= '0;
                next_free <= FREE_W'(1);
              end
            end
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (hit) begin
            cur   <= link_rdata;
            level <= level + LVL_W'(1);
            state <= S_META;
          end else if (item_q.cmd != CMD_INSERT) begin
            done                 <= 1'b1;
            result.read_material <= '0;
            result.status        <= STAT_DONE;
            state                <= S_IDLE;
          end else if (pool_full) begin
            done                 <= 1'b1;
            result.read_material <= '0;
            result.status        <= STAT_FULL;
            state                <= S_IDLE;
          end else begin
            if (cur == '0) begin
              root_mask <= root_mask | oct_bit;
            end
            next_free <= next_free + FREE_W'(1);
            cur       <= new_node;
            level     <= level + LVL_W'(1);
            state     <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          meta  <= '0;
          state <= at_last ? S_FIN : S_CHK;
        end
        S_META: begin
          // link RAM is read at the child here, data ready in S_CHK
          meta  <= node_rdata;
          state <= at_last ? S_FIN : S_CHK;
        end
        S_FIN: begin
          done          <= 1'b1;
          result.status <= STAT_DONE;
          if (item_q.cmd == CMD_READ && meta.leaf) begin
            result.read_material <= meta.material;
          end else begin
            result.read_material <= '0;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    next_free != '0 && next_free <= FREE_W'(NODE_POOL))
    else $error("allocator out of range");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.cmd == CMD_CLEAR |=>
      done && result.status == STAT_DONE && next_free == FREE_W'(1) && root_mask == '0)
    else $error("clear did not reset tree");

  a_full: assert property (@(posedge clk) disable iff (rst)
    done && result.status == STAT_FULL |-> next_free == FREE_W'(NODE_POOL))
    else $error("pool full reported with free nodes");

  a_mat_read: assert property (@(posedge clk) disable iff (rst)
    done && result.read_material != '0 |-> item_q.cmd == CMD_READ)
    else $error("material on non-read result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while walking");
`endif

endmodule

/* src/svo_ram.sv */
// ----------------------------------------------------------------------------
// svo_ram: generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module svo_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* dv/tb_sparse_voxel_octree_store_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_voxel_octree_store_unit: self-checking bench for the octree store
// A directed table covers the field extremes, all commands, empty inserts,
// overwrite and clear with node reuse. Random episodes follow: clustered
// inserts and reads, plus wide fills that run the node pool dry. Every result
// beat is checked against a typed table answer or a local octree model.
// ----------------------------------------------------------------------------
module tb_sparse_voxel_octree_store_unit;
  import svo_pkg::*;

  localparam int unsigned MAX_DEPTH   = DEF_MAX_DEPTH;
  localparam int unsigned NODE_POOL   = DEF_NODE_POOL;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int          VOXEL_BEATS = 1750;
  localparam int          STALL_LIMIT = 2000;
  localparam int          DIR_ROWS    = 21;

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    done;
  result_t result;

  always #2 clk = ~clk;

  sparse_voxel_octree_store_unit #(
    .MAX_DEPTH(MAX_DEPTH),
    .NODE_POOL(NODE_POOL)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .done(done),
    .result(result)
  );

  // local octree: links, leaf marks, materials and the allocator
  int unsigned octree_links [NODE_POOL*8];
  bit          leaf_mark    [NODE_POOL];
  logic [7:0]  leaf_mat     [NODE_POOL];
  int unsigned alloc_next;

  result_t voxel_answers_q [$];
  int      fail_count;
  int      stall_cycles;
  bit      idle_on;
  int      n_inserts, n_full, n_read_hits, n_read_misses, n_clears;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] x;
    logic [5:0] y;
    logic [5:0] z;
    logic [7:0] mat;
    bit         typed;
    logic [7:0] rmat;
    logic [1:0] st;
  } dir_row_t;

  // typed answers only where obvious; the rest come from the model
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{CMD_READ,    6'd0,  6'd0,  6'd0,  8'd0,   1'b1, 8'd0,   STAT_DONE},
    '{CMD_READ,    6'd63, 6'd63, 6'd63, 8'd0,   1'b1, 8'd0,   STAT_DONE},
    '{CMD_INSERT,  6'd0,  6'd0,  6'd0,  8'd0,   1'b1, 8'd0,   STAT_EMPTY},
    '{CMD_INSERT,  6'd63, 6'd63, 6'd63, 8'd255, 1'b1, 8'd0,   STAT_DONE},
    '{CMD_READ,    6'd63, 6'd63, 6'd63, 8'd0,   1'b1, 8'd255, STAT_DONE},
    '{CMD_INSERT,  6'd0,  6'd0,  6'd0,  8'd1,   1'b1, 8'd0,   STAT_DONE},
    '{CMD_READ,    6'd0,  6'd0,  6'd0,  8'd0,   1'b1, 8'd1,   STAT_DONE},
    '{CMD_READ,    6'd63, 6'd63, 6'd62, 8'd0,   1'b1, 8'd0,   STAT_DONE},
    '{CMD_INSERT,  6'd63, 6'd63, 6'd63, 8'h5a,  1'b1, 8'd0,   STAT_DONE},
    '{CMD_READ,    6'd63, 6'd63, 6'd63, 8'd0,   1'b1, 8'h5a,  STAT_DONE},
    '{CMD_UNUSED,  6'd63, 6'd0,  6'd63, 8'hff,  1'b1, 8'd0,   STAT_DONE},
    '{CMD_INSERT,  6'd21, 6'd42, 6'd21, 8'ha5,  1'b0, 8'd0,   STAT_DONE},
    '{CMD_READ,    6'd42, 6'd21, 6'd42, 8'd0,   1'b0, 8'd0,   STAT_DONE},
    '{CMD_READ,    6'd21, 6'd42, 6'd21, 8'd0,   1'b1, 8'ha5,  STAT_DONE},
    '{CMD_CLEAR,   6'd42, 6'd21, 6'd42, 8'h5a,  1'b1, 8'd0,   STAT_DONE},
    '{CMD_READ,    6'd63, 6'd63, 6'd63, 8'd0,   1'b1, 8'd0,   STAT_DONE},
    '{CMD_READ,    6'd21, 6'd42, 6'd21, 8'd0,   1'b1, 8'd0,   STAT_DONE},
    '{CMD_INSERT,  6'd63, 6'd63, 6'd63, 8'd7,   1'b1, 8'd0,   STAT_DONE},
    // reused nodes must not show links from before the clear
    '{CMD_READ,    6'd63, 6'd63, 6'd0,  8'd0,   1'b1, 8'd0,   STAT_DONE},
    '{CMD_READ,    6'd63, 6'd63, 6'd63, 8'd0,   1'b1, 8'd7,   STAT_DONE},
    '{CMD_CLEAR,   6'd0,  6'd0,  6'd0,  8'd0,   1'b1, 8'd0,   STAT_DONE}
  };

  function automatic result_t octree_predict(input item_t it);
    result_t     res;
    int unsigned node;
    int unsigned nxt;
    int unsigned lvl;
    int unsigned b;
    logic [2:0]  oct;
    bit          walking;
    res = '0;
    res.status = STAT_DONE;
    node = 0;
    case (it.cmd)
      CMD_INSERT: begin
        if (it.material == 8'd0) begin
          res.status = STAT_EMPTY;
        end else begin
          walking = 1'b1;
          for (lvl = 0; lvl < MAX_DEPTH && walking; lvl++) begin
            b = MAX_DEPTH - 1 - lvl;
            oct = {it.pos_z[b], it.pos_y[b], it.pos_x[b]};
            nxt = octree_links[node*8 + oct];
            if (nxt == 0) begin
              if (alloc_next >= NODE_POOL) begin
                res.status = STAT_FULL;
                walking = 1'b0;
              end else begin
                nxt = alloc_next;
                alloc_next++;
                for (int k = 0; k < 8; k++) octree_links[nxt*8 + k] = 0;
                leaf_mark[nxt] = 1'b0;
                octree_links[node*8 + oct] = nxt;
              end
            end
            if (walking) node = nxt;
          end
          if (walking) begin
            leaf_mark[node] = 1'b1;
            leaf_mat[node] = it.material;
            n_inserts++;
          end else begin
            n_full++;
          end
        end
      end
      CMD_READ: begin
        lvl = 0;
        walking = 1'b1;
        while (walking) begin
          if (leaf_mark[node]) begin
            res.read_material = leaf_mat[node];
            walking = 1'b0;
          end else if (lvl >= MAX_DEPTH) begin
            walking = 1'b0;
          end else begin
            b = MAX_DEPTH - 1 - lvl;
            oct = {it.pos_z[b], it.pos_y[b], it.pos_x[b]};
            nxt = octree_links[node*8 + oct];
            if (nxt == 0) walking = 1'b0;
            else node = nxt;
            lvl++;
          end
        end
        if (res.read_material != 8'd0) n_read_hits++;
        else n_read_misses++;
      end
      CMD_CLEAR: begin
        for (int k = 0; k < 8; k++) octree_links[k] = 0;
        leaf_mark[0] = 1'b0;
        alloc_next = 1;
        n_clears++;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic item_t make_beat(input logic [1:0] c, input logic [17:0] xyz,
                                      input logic [7:0] m);
    item_t it;
    it.cmd = c;
    {it.pos_x, it.pos_y, it.pos_z} = xyz;
    it.material = m;
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_beat(input item_t it, input bit typed, input result_t typed_res);
    result_t res;
    if (idle_on && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      // idle only where the block could take a beat
      while (busy) @(negedge clk);
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    res = octree_predict(it);
    voxel_answers_q.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (voxel_answers_q.size() == 0) begin
        $error("result beat with nothing expected: read_material %0d status %0d",
               result.read_material, result.status);
        fail_count++;
      end else begin
        want = voxel_answers_q.pop_front();
        if (result.read_material !== want.read_material) begin
          $error("read_material: expected %0d, got %0d",
                 want.read_material, result.read_material);
          fail_count++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          fail_count++;
        end
      end
    end
  end

  // watchdog: cycles with no beat moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("sparse_voxel_octree_store_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    logic [17:0] written_q [$];
    logic [17:0] base, span, xyz;
    int          beats_sent;
    int          ep_len;
    int          r;
    bit          fill;
    result_t     typed_res;

    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    fail_count = 0;
    stall_cycles = 0;
    idle_on = 1'b1;
    n_inserts = 0; n_full = 0; n_read_hits = 0; n_read_misses = 0; n_clears = 0;
    for (int i = 0; i < NODE_POOL*8; i++) octree_links[i] = 0;
    for (int i = 0; i < NODE_POOL; i++) begin
      leaf_mark[i] = 1'b0;
      leaf_mat[i]  = 8'd0;
    end
    alloc_next = 1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      typed_res.read_material = dir_rows[i].rmat;
      typed_res.status        = dir_rows[i].st;
      send_beat(make_beat(dir_rows[i].cmd, {dir_rows[i].x, dir_rows[i].y, dir_rows[i].z},
                          dir_rows[i].mat), dir_rows[i].typed, typed_res);
    end

    // random episodes: clustered traffic, or a wide fill that exhausts the pool
    typed_res = '0;
    beats_sent = 0;
    while (beats_sent < VOXEL_BEATS) begin
      fill = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        send_beat(make_beat(CMD_CLEAR, 18'($urandom), 8'($urandom)), 1'b0, typed_res);
        written_q.delete();
        beats_sent++;
      end
      base = 18'($urandom);
      if (fill) begin
        span   = '1;
        ep_len = $urandom_range(150, 300);
      end else begin
        r      = $urandom_range(1, 3);
        span   = {3{6'((1 << r) - 1)}};
        ep_len = $urandom_range(10, 60);
      end
      for (int n = 0; n < ep_len && beats_sent < VOXEL_BEATS; n++) begin
        // no idling through a long middle stretch
        idle_on = !(beats_sent >= 700 && beats_sent < 1000);
        xyz = (base & ~span) | (18'($urandom) & span);
        r = $urandom_range(0, 99);
        if (r < 50 || (r < 60 && written_q.size() == 0)) begin
          send_beat(make_beat(CMD_INSERT, xyz, 8'($urandom_range(1, 255))),
                    1'b0, typed_res);
          written_q.push_back(xyz);
          beats_sent++;
        end else if (r < 60) begin
          xyz = written_q[$urandom_range(0, written_q.size() - 1)];
          send_beat(make_beat(CMD_INSERT, xyz, 8'($urandom_range(1, 255))),
                    1'b0, typed_res);
          beats_sent++;
        end else if (r < 93) begin
          if (r < 85 && written_q.size() != 0)
            xyz = written_q[$urandom_range(0, written_q.size() - 1)];
          send_beat(make_beat(CMD_READ, xyz, 8'($urandom)), 1'b0, typed_res);
          beats_sent++;
        end else if (r < 96) begin
          send_beat(make_beat(CMD_INSERT, xyz, 8'd0), 1'b0, typed_res);
        end else if (r < 98) begin
          send_beat(make_beat(CMD_UNUSED, 18'($urandom), 8'($urandom)), 1'b0, typed_res);
        end else begin
          send_beat(make_beat(CMD_CLEAR, xyz, 8'($urandom)), 1'b0, typed_res);
          written_q.delete();
          beats_sent++;
        end
      end
    end

    start <= 1'b0;
    while (voxel_answers_q.size() != 0) @(posedge clk);
    repeat (2*MAX_DEPTH + 4) @(posedge clk);

    $display("covered %0d voxel beats after the directed table: %0d inserts stored,",
             beats_sent, n_inserts);
    $display("%0d pool-full stops, %0d read hits, %0d read misses, %0d clears",
             n_full, n_read_hits, n_read_misses, n_clears);
    if (fail_count == 0) begin
      $display("sparse_voxel_octree_store_unit: match");
    end else begin
      $display("sparse_voxel_octree_store_unit: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
src/svo_pkg.sv
src/svo_ram.sv
src/sparse_voxel_octree_store_unit.sv
dv/tb_sparse_voxel_octree_store_unit.sv
